/* hw/rtl/prime_test_trial_division_macros.svh */
// assertion macros for the trial division primality block
// used by the checker module, no other dependencies
`ifndef PRIME_TEST_TRIAL_DIVISION_MACROS_SVH
`define PRIME_TEST_TRIAL_DIVISION_MACROS_SVH

// property must hold at every clock edge outside reset
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define PTD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hw/rtl/ptd_pkg.sv */
// shared constants, codes and controller/datapath types
// for the trial division primality block, no dependencies
package ptd_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam logic ACT_TEST = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	localparam logic [1:0] CAND_N    = 2'd0;
	localparam logic [1:0] CAND_N1   = 2'd1;
	localparam logic [1:0] CAND_N2   = 2'd2;
	localparam logic [1:0] CAND_ADD2 = 2'd3;

	localparam logic [2:0] RES_NOTPRIME = 3'd0;
	localparam logic [2:0] RES_PRIME    = 3'd1;
	localparam logic [2:0] RES_TWO      = 3'd2;
	localparam logic [2:0] RES_OVF      = 3'd3;
	localparam logic [2:0] RES_CAND     = 3'd4;

	typedef struct packed {
		logic       load;
		logic       cand_load;
		logic [1:0] cand_sel;
		logic       d_init;
		logic       d_add2;
		logic       div_start;
		logic       div_step;
		logic       res_set;
		logic [2:0] res_kind;
		logic       out_load;
	} ptd_cmd_t;

	typedef struct packed {
		logic act;
		logic lt2;
		logic eq2;
		logic even;
		logic n_max;
		logic c_max;
		logic div_last;
		logic d_gt_q;
		logic rem_zero;
		logic out_free;
	} ptd_status_t;

endpackage

/* hw/rtl/ptd_in_if.sv */
// input channel of the trial division primality block
// depends on ptd_pkg for the default width
interface ptd_in_if #(
	parameter int unsigned W = ptd_pkg::VALUE_WIDTH_DEF
);
	logic         valid;
	logic         ready;
	logic         action;
	logic [W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

/* hw/rtl/ptd_out_if.sv */
// output channel of the trial division primality block
// depends on ptd_pkg for the default width
interface ptd_out_if #(
	parameter int unsigned W = ptd_pkg::VALUE_WIDTH_DEF
);
	logic         valid;
	logic         ready;
	logic         is_prime;
	logic [W-1:0] next_prime;
	logic         overflow;

	modport source (output valid, output is_prime, output next_prime, output overflow,
		input ready);
	modport sink (input valid, input is_prime, input next_prime, input overflow,
		output ready);
endinterface

/* hw/rtl/prime_test_trial_division.sv */
// Trial division primality block: one item at a time. An odd operand above 2 is divided by
// 3, 5, 7, ... with a single shared restoring divider that produces one quotient bit per
// cycle; the test stops at the first exact divisor or once the divisor exceeds the quotient.
// A test tries at most about sqrt(value) / 2 trial divisors. In a test, values below 3 and
// even values are settled without any division. A next-prime search repeats the test on
// each odd candidate, so its time is the sum over the candidates tried. The result sits in
// an output register, and the next item is taken as soon as the result has moved there.
module prime_test_trial_division #(
	parameter int unsigned VALUE_WIDTH = ptd_pkg::VALUE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ptd_in_if.sink    query,
	ptd_out_if.source answer
);
	import ptd_pkg::*;

	ptd_cmd_t    cmd;
	ptd_status_t st;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (query.valid),
		.in_ready (query.ready),
		.st       (st),
		.cmd      (cmd)
	);

	ptd_datapath #(
		.W (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.action     (query.action),
		.value      (query.value),
		.out_valid  (answer.valid),
		.out_ready  (answer.ready),
		.is_prime   (answer.is_prime),
		.next_prime (answer.next_prime),
		.overflow   (answer.overflow)
	);

endmodule

/* hw/rtl/ptd_datapath.sv */
// operand, candidate and divisor registers, restoring divider and result stage
// depends on ptd_pkg
module ptd_datapath #(
	parameter int unsigned W = ptd_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptd_pkg::ptd_cmd_t  cmd,
	output ptd_pkg::ptd_status_t st,
	input  logic               action,
	input  logic [W-1:0]       value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_prime,
	output logic [W-1:0]       next_prime,
	output logic               overflow
);
	import ptd_pkg::*;

	localparam int unsigned CNT_W = $clog2(W);

	logic             act_q;
	logic [W-1:0]     n_q;
	logic [W-1:0]     c_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             res_prime_q;
	logic [W-1:0]     res_next_q;
	logic             res_ovf_q;
	logic             out_valid_q;
	logic             out_prime_q;
	logic [W-1:0]     out_next_q;
	logic             out_ovf_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic [W-1:0]     cand_nxt;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_comb begin
		case (cmd.cand_sel)
			CAND_N:  cand_nxt = n_q;
			CAND_N1: cand_nxt = n_q + W'(1);
			CAND_N2: cand_nxt = n_q + W'(2);
			default: cand_nxt = c_q + W'(2);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			n_q   <= value;
		end
		if (cmd.cand_load) begin
			c_q <= cand_nxt;
		end
		if (cmd.d_init) begin
			d_q <= W'(3);
		end else if (cmd.d_add2) begin
			d_q <= d_q + W'(2);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= c_q;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.res_set) begin
			res_prime_q <= (cmd.res_kind == RES_PRIME);
			res_ovf_q   <= (cmd.res_kind == RES_OVF);
			case (cmd.res_kind)
				RES_TWO:  res_next_q <= W'(2);
				RES_CAND: res_next_q <= c_q;
				default:  res_next_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_prime_q <= res_prime_q;
			out_next_q  <= res_next_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.act      = act_q;
	assign st.lt2      = (n_q[W-1:1] == '0);
	assign st.eq2      = (n_q == W'(2));
	assign st.even     = !n_q[0];
	assign st.n_max    = &n_q;
	assign st.c_max    = &c_q[W-1:1];
	assign st.div_last = (cnt_q == CNT_W'(W - 1));
	assign st.d_gt_q   = (d_q > quo_q);
	assign st.rem_zero = (rem_q == '0);
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign is_prime   = out_prime_q;
	assign next_prime = out_next_q;
	assign overflow   = out_ovf_q;

endmodule

/* hw/rtl/ptd_ctrl.sv */
// sequencing state machine for the trial division primality block
// depends on ptd_pkg
module ptd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ptd_pkg::ptd_status_t st,
	output ptd_pkg::ptd_cmd_t    cmd
);
	import ptd_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CLASSIFY = 3'd1;
	localparam logic [2:0] S_DIV_INIT = 3'd2;
	localparam logic [2:0] S_DIV_RUN  = 3'd3;
	localparam logic [2:0] S_EVAL     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CLASSIFY;
				end
			end
			S_CLASSIFY: begin
				cmd.d_init = 1'b1;
				if (st.act == ACT_TEST) begin
					if (st.lt2 || (st.even && !st.eq2)) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_NOTPRIME;
						state_nxt    = S_DONE;
					end else if (st.eq2) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_PRIME;
						state_nxt    = S_DONE;
					end else begin
						cmd.cand_load = 1'b1;
						cmd.cand_sel  = CAND_N;
						state_nxt     = S_DIV_INIT;
					end
				end else begin
					if (st.lt2) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_TWO;
						state_nxt    = S_DONE;
					end else if (st.even) begin
						cmd.cand_load = 1'b1;
						cmd.cand_sel  = CAND_N1;
						state_nxt     = S_DIV_INIT;
					end else if (st.n_max) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_OVF;
						state_nxt    = S_DONE;
					end else begin
						cmd.cand_load = 1'b1;
						cmd.cand_sel  = CAND_N2;
						state_nxt     = S_DIV_INIT;
					end
				end
			end
			S_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_DIV_RUN;
			end
			S_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				if (st.d_gt_q) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = (st.act == ACT_NEXT) ? RES_CAND : RES_PRIME;
					state_nxt    = S_DONE;
				end else if (st.rem_zero) begin
					if (st.act == ACT_TEST) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_NOTPRIME;
						state_nxt    = S_DONE;
					end else if (st.c_max) begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_OVF;
						state_nxt    = S_DONE;
					end else begin
						cmd.cand_load = 1'b1;
						cmd.cand_sel  = CAND_ADD2;
						cmd.d_init    = 1'b1;
						state_nxt     = S_DIV_INIT;
					end
				end else begin
					cmd.d_add2 = 1'b1;
					state_nxt  = S_DIV_INIT;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/ptd_checker.sv */
// port-level checks for the trial division primality block and their binding
// depends on ptd_pkg and prime_test_trial_division_macros.svh
`include "prime_test_trial_division_macros.svh"

module ptd_checker #(
	parameter int unsigned W = ptd_pkg::VALUE_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic         is_prime,
	input logic [W-1:0] next_prime,
	input logic         overflow
);
	import ptd_pkg::*;

	`PTD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "item dropped while stalled")
	`PTD_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && in_ready |=> !in_ready, "second item taken while busy")
	`PTD_ASSERT(a_ovf_alone, clk, arst_n, out_valid && overflow |-> !is_prime && (next_prime == '0), "overflow with other result")
	`PTD_ASSERT_NEVER(a_even_next, clk, arst_n, out_valid && !next_prime[0] && (next_prime != '0) && (next_prime != W'(2)), "even next prime")

endmodule

bind prime_test_trial_division ptd_checker #(
	.W (VALUE_WIDTH)
) u_ptd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (query.valid),
	.in_ready   (query.ready),
	.out_valid  (answer.valid),
	.out_ready  (answer.ready),
	.is_prime   (answer.is_prime),
	.next_prime (answer.next_prime),
	.overflow   (answer.overflow)
);
